// ===== rtl/core/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared codes and controller/datapath interface types for the go-back-N sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam logic [1:0] OP_SEND  = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  localparam logic [1:0] KIND_PDU     = 2'd0;
  localparam logic [1:0] KIND_REFUSED = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;

  localparam logic REG_WINDOW  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  typedef struct packed {
    logic accept;
    logic decode;
    logic win_step;
    logic rs_start;
    logic rs_step;
    logic tk_next;
    logic flush;
  } gbn_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       dec_window;
    logic       win_more;
    logic       tk_active;
    logic       tk_expired;
    logic       rs_done;
    logic       last_slot;
    logic       out_free;
    logic       pend_valid;
  } gbn_sts_t;

endpackage

// ===== rtl/core/go_back_n_sender.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender
// Go-back-N sender bookkeeping over a fixed set of message slots.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one command word: send, ack, tick
// or query. Output channel (out_valid/out_ready) returns result words; the
// word that closes a command carries last. A command with no result returns
// nothing. Configuration (cfg_write/cfg_index/cfg_data) sets the window size
// and resend timeout; the user must write it only while the block is idle,
// which the block itself does not enforce. One command is in work at a time.
// A query or refused send gives one word; send and ack emit a PDU word for
// each step that refills the window; tick checks each slot, reads the send
// stamp of a slot with PDUs in flight and resends them when it has expired.
// Speed is set by the output stage, one word per cycle while the receiver is
// ready, and by the single read port of the send-stamp memory walked slot by slot.
// Results run one word behind generation so last can be marked; a stalled
// receiver stalls the sequencer, and nothing is dropped.
// Reset clears the slots, the id counter (to 1), the window (4) and the
// timeout (1000 ms); send stamps are written before they are read.
// ----------------------------------------------------------------------------
module go_back_n_sender #(
  parameter int SLOTS      = 4,
  parameter int MAX_PDUS   = 256,
  parameter int WINDOW_MAX = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [8:0]  pdu_count,
  input  logic [31:0] message_id,
  input  logic [31:0] acked_seq,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [31:0] out_message_id,
  output logic [7:0]  pdu_index,
  output logic [8:0]  outstanding,
  output logic        finished,
  output logic        last
);

  gbn_pkg::gbn_cmd_t cmd;
  gbn_pkg::gbn_sts_t sts;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbn_dpath #(
    .SLOTS      (SLOTS),
    .MAX_PDUS   (MAX_PDUS),
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op             (op),
    .pdu_count      (pdu_count),
    .message_id     (message_id),
    .acked_seq      (acked_seq),
    .now_ms         (now_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .out_message_id (out_message_id),
    .pdu_index      (pdu_index),
    .outstanding    (outstanding),
    .finished       (finished),
    .last           (last)
  );

endmodule

// ===== rtl/core/gbn_ram.sv =====
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/gbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer for decode, window fill, timeout walk, resend and final flush.
// ----------------------------------------------------------------------------
module gbn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gbn_pkg::gbn_sts_t sts,
  output gbn_pkg::gbn_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_WINDOW = 8'b0000_0100,
    S_TCHK   = 8'b0000_1000,
    S_TREAD  = 8'b0001_0000,
    S_RESEND = 8'b0010_0000,
    S_FLUSH  = 8'b0100_0000,
    S_SPARE  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.out_free) begin
          cmd.decode = 1'b1;
          if (sts.op == gbn_pkg::OP_TICK) begin
            state_next = S_TCHK;
          end else if (sts.dec_window) begin
            state_next = S_WINDOW;
          end else begin
            state_next = S_FLUSH;
          end
        end
      end
      S_WINDOW: begin
        if (!sts.win_more) begin
          state_next = S_FLUSH;
        end else if (sts.out_free) begin
          cmd.win_step = 1'b1;
        end
      end
      S_TCHK: begin
        if (sts.tk_active) begin
          state_next = S_TREAD;
        end else if (sts.last_slot) begin
          state_next = S_FLUSH;
        end else begin
          cmd.tk_next = 1'b1;
        end
      end
      S_TREAD: begin
        if (sts.tk_expired) begin
          cmd.rs_start = 1'b1;
          state_next   = S_RESEND;
        end else if (sts.last_slot) begin
          state_next = S_FLUSH;
        end else begin
          cmd.tk_next = 1'b1;
          state_next  = S_TCHK;
        end
      end
      S_RESEND: begin
        if (sts.out_free) begin
          cmd.rs_step = 1'b1;
          if (sts.rs_done) begin
            if (sts.last_slot) begin
              state_next = S_FLUSH;
            end else begin
              cmd.tk_next = 1'b1;
              state_next  = S_TCHK;
            end
          end
        end
      end
      S_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/gbn_dpath.sv =====
// ----------------------------------------------------------------------------
// gbn_dpath
// Slot table, configuration, send-stamp memory and one-word-behind output stage.
// ----------------------------------------------------------------------------
module gbn_dpath #(
  parameter int SLOTS      = 4,
  parameter int MAX_PDUS   = 256,
  parameter int WINDOW_MAX = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  gbn_pkg::gbn_cmd_t cmd,
  output gbn_pkg::gbn_sts_t sts,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [1:0]        op,
  input  logic [8:0]        pdu_count,
  input  logic [31:0]       message_id,
  input  logic [31:0]       acked_seq,
  input  logic [31:0]       now_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        kind,
  output logic [31:0]       out_message_id,
  output logic [7:0]        pdu_index,
  output logic [8:0]        outstanding,
  output logic              finished,
  output logic              last
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = $clog2(MAX_PDUS + 1);
  localparam int JW    = $clog2(MAX_PDUS);
  localparam int WW    = $clog2(((WINDOW_MAX > 4) ? WINDOW_MAX : 4) + 1);
  localparam int DEPTH = SLOTS * MAX_PDUS;
  localparam int AW    = $clog2(DEPTH);

  logic [1:0]    op_q;
  logic [8:0]    count_q;
  logic [31:0]   mid_q;
  logic [31:0]   hso_q;
  logic [31:0]   now_q;
  logic [31:0]   next_id;
  logic [WW-1:0] window;
  logic [31:0]   timeout;
  logic [SW-1:0] cur;
  logic [JW-1:0] j;

  logic          busy  [SLOTS];
  logic [31:0]   msg   [SLOTS];
  logic [CW-1:0] total [SLOTS];
  logic [CW-1:0] base  [SLOTS];
  logic [CW-1:0] nxt   [SLOTS];

  logic          pend_valid;
  logic [1:0]    pend_kind;
  logic [31:0]   pend_id;
  logic [7:0]    pend_idx;
  logic [8:0]    pend_outst;
  logic          pend_fin;

  logic [31:0]   key;
  logic          hit;
  logic [SW-1:0] hit_slot;
  logic          any_free;
  logic [SW-1:0] free_slot;
  logic [SW-1:0] sel;
  logic          refuse;
  logic [CW-1:0] maxi;
  logic [CW-1:0] ack_idx;
  logic [CW-1:0] new_base;
  logic          ack_adv;
  logic          ack_done;

  logic          gen;
  logic [1:0]    gen_kind;
  logic [31:0]   gen_id;
  logic [CW-1:0] gen_idx;
  logic [31:0]   gen_idx32;
  logic [CW-1:0] gen_outst;
  logic [31:0]   gen_outst32;
  logic          gen_fin;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic [CW-1:0] widx;
  logic [4:0]    cfg_w5;
  logic [WW-1:0] cfg_win;

  // slot lookup, lowest slot wins
  always_comb begin
    key       = (op_q == gbn_pkg::OP_SEND) ? next_id : mid_q;
    hit       = 1'b0;
    hit_slot  = '0;
    any_free  = 1'b0;
    free_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (busy[s] && msg[s] == key) begin
        hit      = 1'b1;
        hit_slot = SW'(s);
      end
      if (!busy[s]) begin
        any_free  = 1'b1;
        free_slot = SW'(s);
      end
    end
  end

  always_comb begin
    sel      = (op_q == gbn_pkg::OP_SEND && !hit) ? free_slot : hit_slot;
    refuse   = (count_q == 9'd0) || (32'(count_q) > MAX_PDUS) || !(hit || any_free);
    maxi     = total[hit_slot] - CW'(1);
    ack_idx  = (hso_q < 32'(maxi)) ? CW'(hso_q) : maxi;
    new_base = ack_idx + CW'(1);
    ack_adv  = hit && (new_base > base[hit_slot]);
    ack_done = new_base >= total[hit_slot];
  end

  always_comb begin
    sts.op         = op_q;
    sts.dec_window = (op_q == gbn_pkg::OP_SEND) ? !refuse :
                     (op_q == gbn_pkg::OP_ACK)  ? (ack_adv && !ack_done) : 1'b0;
    sts.win_more   = (nxt[cur] < total[cur]) &&
                     (32'(nxt[cur]) < 32'(base[cur]) + 32'(window));
    sts.tk_active  = busy[cur] && (base[cur] < nxt[cur]);
    sts.tk_expired = (ram_rdata != 32'd0) && ((now_q - ram_rdata) >= timeout);
    sts.rs_done    = (32'(j) + 32'd1) == 32'(nxt[cur]);
    sts.last_slot  = cur == SW'(SLOTS - 1);
    sts.out_free   = !out_valid || out_ready;
    sts.pend_valid = pend_valid;
  end

  // result generation
  always_comb begin
    gen = (cmd.decode && (op_q == gbn_pkg::OP_QUERY || (op_q == gbn_pkg::OP_SEND && refuse)))
          || cmd.win_step || cmd.rs_step;
    gen_kind  = gbn_pkg::KIND_PDU;
    gen_id    = msg[cur];
    gen_idx   = cmd.win_step ? nxt[cur] : CW'(j);
    gen_outst = '0;
    gen_fin   = 1'b0;
    if (cmd.decode) begin
      gen_idx = '0;
      if (op_q == gbn_pkg::OP_QUERY) begin
        gen_kind  = gbn_pkg::KIND_QUERY;
        gen_id    = mid_q;
        gen_outst = hit ? (nxt[hit_slot] - base[hit_slot]) : '0;
        gen_fin   = !hit;
      end else begin
        gen_kind = gbn_pkg::KIND_REFUSED;
        gen_id   = next_id;
      end
    end
    gen_idx32   = 32'(gen_idx);
    gen_outst32 = 32'(gen_outst);
  end

  // stamp memory
  always_comb begin
    widx      = cmd.win_step ? nxt[cur] : CW'(j);
    ram_we    = cmd.win_step || cmd.rs_step;
    ram_waddr = AW'(32'(cur) * MAX_PDUS + 32'(widx));
    ram_raddr = AW'(32'(cur) * MAX_PDUS + 32'(base[cur]));
  end

  gbn_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_stamp (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (now_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cfg_w5  = cfg_data[4:0];
    cfg_win = (cfg_w5 == 5'd0) ? WW'(1) :
              (32'(cfg_w5) > WINDOW_MAX) ? WW'(WINDOW_MAX) : WW'(cfg_w5);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      next_id    <= 32'd1;
      window     <= WW'(4);
      timeout    <= 32'd1000;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        busy[s] <= 1'b0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          gbn_pkg::REG_WINDOW:  window  <= cfg_win;
          gbn_pkg::REG_TIMEOUT: timeout <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
          default: ;
        endcase
      end
      if (cmd.decode) begin
        if (op_q == gbn_pkg::OP_SEND) begin
          next_id <= next_id + 32'd1;
          if (!refuse) begin
            busy[sel] <= 1'b1;
          end
        end else if (op_q == gbn_pkg::OP_ACK && ack_adv && ack_done) begin
          busy[hit_slot] <= 1'b0;
        end
      end
      if (cmd.flush) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (gen) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_valid <= 1'b1;
        end else if (out_ready) begin
          out_valid <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q    <= op;
      count_q <= pdu_count;
      mid_q   <= message_id;
      hso_q   <= acked_seq;
      now_q   <= now_ms;
    end
    if (cmd.decode) begin
      unique case (op_q)
        gbn_pkg::OP_SEND: begin
          if (!refuse) begin
            msg[sel]   <= next_id;
            total[sel] <= CW'(count_q);
            base[sel]  <= '0;
            nxt[sel]   <= '0;
            cur        <= sel;
          end
        end
        gbn_pkg::OP_ACK: begin
          if (ack_adv) begin
            base[hit_slot] <= new_base;
          end
          cur <= hit_slot;
        end
        gbn_pkg::OP_TICK: begin
          cur <= '0;
        end
        default: ;
      endcase
    end
    if (cmd.win_step) begin
      nxt[cur] <= nxt[cur] + CW'(1);
    end
    if (cmd.rs_start) begin
      j <= JW'(base[cur]);
    end
    if (cmd.rs_step) begin
      j <= j + JW'(1);
    end
    if (cmd.tk_next) begin
      cur <= cur + SW'(1);
    end
    if (cmd.flush) begin
      kind           <= pend_kind;
      out_message_id <= pend_id;
      pdu_index      <= pend_idx;
      outstanding    <= pend_outst;
      finished       <= pend_fin;
      last           <= 1'b1;
    end else if (gen) begin
      if (pend_valid) begin
        kind           <= pend_kind;
        out_message_id <= pend_id;
        pdu_index      <= pend_idx;
        outstanding    <= pend_outst;
        finished       <= pend_fin;
        last           <= 1'b0;
      end
      pend_kind  <= gen_kind;
      pend_id    <= gen_id;
      pend_idx   <= gen_idx32[7:0];
      pend_outst <= gen_outst32[8:0];
      pend_fin   <= gen_fin;
    end
  end

endmodule

// ===== rtl/core/gbn_checker.sv =====
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks on result words of the go-back-N sender.
// ----------------------------------------------------------------------------
module gbn_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [7:0]  pdu_index,
  input logic [8:0]  outstanding,
  input logic        finished,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(pdu_index))
    else $error("result word changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == gbn_pkg::KIND_PDU || kind == gbn_pkg::KIND_REFUSED ||
                   kind == gbn_pkg::KIND_QUERY))
    else $error("undefined result kind");

  a_pdu_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != gbn_pkg::KIND_QUERY |-> outstanding == 9'd0 && !finished)
    else $error("query fields set on non-query word");

  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != gbn_pkg::KIND_PDU |-> last && pdu_index == 8'd0)
    else $error("refusal or query word not closing");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result word right after reset");

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .kind        (kind),
  .pdu_index   (pdu_index),
  .outstanding (outstanding),
  .finished    (finished),
  .last        (last)
);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the go-back-N sender against a behavioral model of its slot
// bookkeeping: directed sends, acks, ticks and queries, then random traffic
// under bursty input and a stalling receiver, across several window and
// timeout settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int SLOTS = 4;
  localparam int MAX_PDUS = 256;
  localparam int WINDOW_MAX = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] mid;
    logic [7:0]  idx;
    logic [8:0]  outst;
    logic        fin;
    logic        last;
  } result_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [8:0]  pdu_count;
  logic [31:0] message_id;
  logic [31:0] acked_seq;
  logic [31:0] now_ms;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [31:0] out_message_id;
  logic [7:0]  pdu_index;
  logic [8:0]  outstanding;
  logic        finished;
  logic        last;

  go_back_n_sender dut (.*);

  // model state
  logic [4:0]  win;
  logic [31:0] tmo;
  logic [31:0] id_ctr;
  logic        busy [SLOTS];
  logic [31:0] msg [SLOTS];
  logic [8:0]  total [SLOTS];
  logic [8:0]  base [SLOTS];
  logic [8:0]  nxt [SLOTS];
  logic [31:0] stamp [SLOTS][MAX_PDUS];

  result_t     pending_words[$];
  int          errors;
  int          hold_off;
  logic [31:0] clock_ms;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void model_reset();
    win = 4;
    tmo = 1000;
    id_ctr = 1;
    for (int s = 0; s < SLOTS; s++) begin
      busy[s] = 0; msg[s] = 0; total[s] = 0; base[s] = 0; nxt[s] = 0;
    end
  endfunction

  function automatic void push_word(logic [1:0] k, logic [31:0] m, logic [7:0] i,
                                    logic [8:0] o, logic f);
    result_t r;
    r.kind = k; r.mid = m; r.idx = i; r.outst = o; r.fin = f; r.last = 0;
    pending_words = {pending_words, r};
  endfunction

  function automatic void fill_window(int s, logic [31:0] now);
    while (nxt[s] < total[s] && 32'(nxt[s]) < 32'(base[s]) + 32'(win)) begin
      stamp[s][nxt[s]] = now;
      push_word(gbn_pkg::KIND_PDU, msg[s], nxt[s][7:0], 0, 0);
      nxt[s]++;
    end
  endfunction

  function automatic void predict(logic [1:0] o, logic [8:0] cnt, logic [31:0] mid,
                                  logic [31:0] hso, logic [31:0] now);
    int before_n, s, k;
    logic [31:0] id, maxi, ix;
    before_n = pending_words.size();
    s = -1;
    if (o == gbn_pkg::OP_SEND) begin
      id = id_ctr;
      id_ctr = id_ctr + 1;
      for (k = 0; k < SLOTS; k++) if (s < 0 && busy[k] && msg[k] == id) s = k;
      for (k = 0; k < SLOTS; k++) if (s < 0 && !busy[k]) s = k;
      if (cnt == 0 || cnt > MAX_PDUS || s < 0)
        push_word(gbn_pkg::KIND_REFUSED, id, 0, 0, 0);
      else begin
        busy[s] = 1; msg[s] = id; total[s] = cnt; base[s] = 0; nxt[s] = 0;
        fill_window(s, now);
      end
    end else if (o == gbn_pkg::OP_ACK || o == gbn_pkg::OP_QUERY) begin
      for (k = 0; k < SLOTS; k++) if (s < 0 && busy[k] && msg[k] == mid) s = k;
      if (o == gbn_pkg::OP_QUERY) begin
        if (s >= 0) push_word(gbn_pkg::KIND_QUERY, mid, 0, nxt[s] - base[s], 0);
        else push_word(gbn_pkg::KIND_QUERY, mid, 0, 0, 1);
      end else if (s >= 0) begin
        maxi = 32'(total[s]) - 1;
        ix = hso < maxi ? hso : maxi;
        if (ix + 1 > 32'(base[s])) begin
          base[s] = 9'(ix + 1);
          if (base[s] >= total[s]) busy[s] = 0;
          else fill_window(s, now);
        end
      end
    end else begin
      for (s = 0; s < SLOTS; s++) begin
        if (!busy[s] || base[s] >= nxt[s]) continue;
        if (stamp[s][base[s]] == 0 || now - stamp[s][base[s]] < tmo) continue;
        for (int j = base[s]; j < nxt[s]; j++) begin
          stamp[s][j] = now;
          push_word(gbn_pkg::KIND_PDU, msg[s], 8'(j), 0, 0);
        end
      end
    end
    if (pending_words.size() > before_n)
      pending_words[pending_words.size() - 1].last = 1;
  endfunction

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else begin
      if (out_valid && out_ready) begin
        result_t got, exp_w;
        got = '{kind, out_message_id, pdu_index, outstanding, finished, last};
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word, got %h", $time, got);
          errors++;
        end else begin
          exp_w = pending_words.pop_front();
          if (got !== exp_w) begin
            $display("%0t: mismatch, expected %h actual %h", $time, exp_w, got);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 0;
      end else out_ready <= ($urandom_range(0, 3) != 0) || ($time / 20000 % 2 == 0);
    end
  end

  task automatic send_word(logic [1:0] o, logic [8:0] cnt, logic [31:0] mid,
                           logic [31:0] hso, logic [31:0] now);
    op <= o; pdu_count <= cnt; message_id <= mid; acked_seq <= hso;
    now_ms <= now; in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    predict(o, cnt, mid, hso, now);
    if ($urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    int guard;
    in_valid <= 0;
    guard = 0;
    while (pending_words.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic ix, logic [31:0] d);
    cfg_write <= 1; cfg_index <= ix; cfg_data <= d;
    @(posedge clk);
    cfg_write <= 0;
    if (ix == gbn_pkg::REG_WINDOW) begin
      win = d[4:0] == 0 ? 5'd1 : (d[4:0] > WINDOW_MAX ? 5'(WINDOW_MAX) : d[4:0]);
    end else tmo = d == 0 ? 32'd1 : d;
  endtask

  function automatic logic [31:0] live_id();
    int s;
    s = $urandom_range(0, SLOTS - 1);
    return busy[s] ? msg[s] : id_ctr - 32'($urandom_range(1, 6));
  endfunction

  task automatic test_directed();
    send_word(gbn_pkg::OP_SEND, 0, 0, 0, 5);
    send_word(gbn_pkg::OP_SEND, 257, 0, 0, 5);
    send_word(gbn_pkg::OP_SEND, 511, 0, 0, 5);
    send_word(gbn_pkg::OP_SEND, 256, 0, 0, 0);
    send_word(gbn_pkg::OP_SEND, 1, 0, 0, 10);
    send_word(gbn_pkg::OP_SEND, 10, 0, 0, 10);
    send_word(gbn_pkg::OP_SEND, 3, 0, 0, 32'hFFFF_FFFF);
    send_word(gbn_pkg::OP_SEND, 5, 0, 0, 10);
    send_word(gbn_pkg::OP_QUERY, 0, 6, 0, 10);
    send_word(gbn_pkg::OP_QUERY, 0, 32'hFFFF_FFFF, 0, 10);
    send_word(gbn_pkg::OP_TICK, 0, 0, 0, 2000);
    send_word(gbn_pkg::OP_ACK, 0, 5, 32'hFFFF_FFFF, 2000);
    send_word(gbn_pkg::OP_ACK, 0, 99, 2, 2000);
    send_word(gbn_pkg::OP_ACK, 0, 6, 1, 2100);
    send_word(gbn_pkg::OP_ACK, 0, 6, 0, 2100);
    send_word(gbn_pkg::OP_TICK, 0, 0, 0, 2500);
    send_word(gbn_pkg::OP_TICK, 0, 0, 0, 4000);
    send_word(gbn_pkg::OP_QUERY, 0, 6, 0, 4000);
    send_word(gbn_pkg::OP_ACK, 0, 7, 2, 4000);
    send_word(gbn_pkg::OP_SEND, 2, 0, 0, 4000);
    send_word(gbn_pkg::OP_ACK, 0, 4, 0, 4000);
    drain();
  endtask

  task automatic test_random(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      clock_ms = clock_ms + $urandom_range(0, 400);
      pick = $urandom_range(0, 9);
      if (pick < 3)
        send_word(gbn_pkg::OP_SEND, $urandom_range(0, 9) == 0 ? 9'($urandom) :
                  9'($urandom_range(1, 24)), $urandom, $urandom, clock_ms);
      else if (pick < 6)
        send_word(gbn_pkg::OP_ACK, $urandom,
                  $urandom_range(0, 9) == 0 ? $urandom : live_id(),
                  $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 20), clock_ms);
      else if (pick < 8)
        send_word(gbn_pkg::OP_TICK, $urandom, $urandom, $urandom,
                  $urandom_range(0, 15) == 0 ? $urandom : clock_ms);
      else
        send_word(gbn_pkg::OP_QUERY, $urandom,
                  $urandom_range(0, 5) == 0 ? $urandom : live_id(),
                  $urandom, clock_ms);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    for (int i = 0; i < 12; i++) send_word(gbn_pkg::OP_SEND, 16, 0, 0, clock_ms);
    drain();
  endtask

  task automatic test_settings();
    write_reg(gbn_pkg::REG_WINDOW, 16);
    write_reg(gbn_pkg::REG_TIMEOUT, 1);
    test_random(50);
    drain();
    write_reg(gbn_pkg::REG_WINDOW, 0);
    write_reg(gbn_pkg::REG_TIMEOUT, 0);
    test_random(40);
    drain();
    write_reg(gbn_pkg::REG_WINDOW, 31);
    write_reg(gbn_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
    test_random(30);
    drain();
    write_reg(gbn_pkg::REG_WINDOW, 3);
    write_reg(gbn_pkg::REG_TIMEOUT, 300);
    test_random(50);
    drain();
  endtask

  initial begin
    errors = 0; hold_off = 0; clock_ms = 100;
    rst = 1; cfg_write = 0; cfg_index = 0; cfg_data = 0; in_valid = 0;
    op = 0; pdu_count = 0; message_id = 0; acked_seq = 0; now_ms = 0;
    model_reset();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_settings();
    if (errors == 0 && pending_words.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
